// File: design/gvn_pkg.sv
// ---------------------------------------------------------------------------
// gvn_pkg : shared types and constants of the grid vertex normal generator
// Field widths, register and operation codes, fixed-point constants and
// the state type of the sequencer.
// ---------------------------------------------------------------------------
package gvn_pkg;

  // payload widths
  localparam int POS_W      = 32;
  localparam int NRM_W      = 16;
  localparam int IDX_W      = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  // word operation codes
  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICES_PER_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_ROWS      = 2'd1;

  // configuration reset values
  localparam logic [CFG_DATA_W-1:0] VPR_RESET  = 9'd65;
  localparam logic [CFG_DATA_W-1:0] ROWS_RESET = 9'd81;

  // floor(1e-6 * 2^64): squared-length threshold
  localparam logic [63:0] DEGEN_LIMIT = 64'd18446744073709;
  // 1.0 in Q1.14
  localparam logic [14:0] ONE_Q14 = 15'd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SCALE,
    ST_MUL,
    ST_CMAG,
    ST_TSHIFT,
    ST_SQ,
    ST_DECIDE,
    ST_SQRT,
    ST_DIVINIT,
    ST_DIV,
    ST_DONE
  } gvn_state_t;

endpackage

// File: design/gvn_vtx_if.sv
// ---------------------------------------------------------------------------
// gvn_vtx_if : vertex input channel
// Valid/ready channel carrying one vertex or flush word.
// ---------------------------------------------------------------------------
interface gvn_vtx_if import gvn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, op, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, op, pos_x, pos_y, pos_z, output ready);
endinterface

// File: design/gvn_nrm_if.sv
// ---------------------------------------------------------------------------
// gvn_nrm_if : normal output channel
// Valid/ready channel carrying one vertex normal word.
// ---------------------------------------------------------------------------
interface gvn_nrm_if import gvn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic [IDX_W-1:0]        vertex_row;
  logic [IDX_W-1:0]        vertex_col;
  logic                    degenerate;
  logic                    last_normal;

  modport source (output valid, normal_x, normal_y, normal_z, vertex_row, vertex_col,
                  degenerate, last_normal, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, vertex_row, vertex_col,
                  degenerate, last_normal, output ready);
endinterface

// File: design/gvn_cfg_if.sv
// ---------------------------------------------------------------------------
// gvn_cfg_if : configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface gvn_cfg_if import gvn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/gvn_ram.sv
// ---------------------------------------------------------------------------
// gvn_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module gvn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/grid_vertex_normal_generator.sv
// ---------------------------------------------------------------------------
// grid_vertex_normal_generator : central-difference normals of a vertex grid
//
//   channel   dir  modport  contents
//   vtx_in    in   sink     op, pos_x, pos_y, pos_z (Q16.16)
//   nrm_out   out  source   normal_x/y/z (Q1.14), vertex_row/col, flags
//   cfg       in   sink     index, data (vertices_per_row, vertex_rows)
//
// Vertices are kept in three row slots of three position RAMs. A word that
// emits a normal passes four RAM reads, up to two difference shifts, a shared
// 32x32 multiplier for cross and square terms, up to 30 product shifts, a
// 32-step square root and a 15-step divide; a degenerate normal skips the
// square root and the divide. Words that emit nothing stay in ST_IDLE.
// rst is synchronous; the grid counters restart on a cfg write to index 0 or 1.
// The finished normal sits in an output register, so the next word is taken
// while it waits for nrm_out.ready; a second normal waits in ST_DONE.
// ---------------------------------------------------------------------------
module grid_vertex_normal_generator import gvn_pkg::*; #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic        clk,
  input  logic        rst,
  gvn_vtx_if.sink     vtx_in,
  gvn_nrm_if.source   nrm_out,
  gvn_cfg_if.sink     cfg
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CXW   = CW + 1;
  localparam int RXW   = RW + 1;
  localparam int CLW   = (CXW > CFG_DATA_W) ? CXW : CFG_DATA_W;
  localparam int RLW   = (RXW > CFG_DATA_W) ? RXW : CFG_DATA_W;
  localparam int TW    = CXW + RXW;
  localparam int ENW   = CW + RW;
  localparam int DEPTH = 3 * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  // configuration and grid position
  logic [CFG_DATA_W-1:0] vpr;
  logic [CFG_DATA_W-1:0] nrows;
  logic [CW-1:0]         input_col;
  logic [RXW-1:0]        input_row;
  logic [1:0]            in_slot;
  logic [ENW-1:0]        emit_count;

  gvn_state_t state, state_next;
  logic [4:0] cnt;

  // effective (clamped) grid size
  logic [CLW-1:0] vpr_ext;
  logic [RLW-1:0] rows_ext;
  logic [CXW-1:0] cols;
  logic [RXW-1:0] rows;

  always_comb begin
    vpr_ext  = CLW'(vpr);
    rows_ext = RLW'(nrows);
    if (vpr_ext < CLW'(2)) begin
      cols = CXW'(2);
    end else if (vpr_ext > CLW'(MAX_COLS)) begin
      cols = CXW'(MAX_COLS);
    end else begin
      cols = CXW'(vpr_ext);
    end
    if (rows_ext < RLW'(2)) begin
      rows = RXW'(2);
    end else if (rows_ext > RLW'(MAX_ROWS)) begin
      rows = RXW'(MAX_ROWS);
    end else begin
      rows = RXW'(rows_ext);
    end
  end

  function automatic logic [AW-1:0] mk_addr(input logic [1:0] sl, input logic [CW-1:0] col);
    return AW'(sl) * AW'(MAX_COLS) + AW'(col);
  endfunction

  // word decode at the input
  logic           accept;
  logic           is_vtx;
  logic           vtx_ok;
  logic           fl_ok;
  logic           emit_go;
  logic           last;
  logic [TW-1:0]  total;
  logic [TW-1:0]  base;
  logic [TW-1:0]  ec_full;
  logic [CW-1:0]  ec;
  logic [CXW-1:0] col_inc;
  logic [CXW-1:0] cl;
  logic [CXW-1:0] cr;
  logic [1:0]     sl_e;
  logic [1:0]     sl_d;
  logic [1:0]     sl_u;
  logic           wr_en;

  assign vtx_in.ready = (state == ST_IDLE);
  assign accept       = vtx_in.valid && vtx_in.ready;
  assign cfg.ready    = 1'b1;

  always_comb begin
    is_vtx  = (vtx_in.op == OP_VERTEX);
    total   = TW'(cols) * TW'(rows);
    base    = TW'(rows - RXW'(1)) * TW'(cols);
    ec_full = TW'(emit_count) - base;
    vtx_ok  = (input_row < rows) && (CXW'(input_col) < cols);
    fl_ok   = (input_row >= rows) && (TW'(emit_count) >= base) && (ec_full < TW'(cols));
    emit_go = is_vtx ? (vtx_ok && (input_row != '0)) : fl_ok;
    last    = (TW'(emit_count) + TW'(1)) >= total;
    ec      = is_vtx ? input_col : ec_full[CW-1:0];
    col_inc = CXW'(input_col) + CXW'(1);
    wr_en   = accept && is_vtx && vtx_ok;
    // neighbour columns, clamped
    cl = (ec == '0) ? '0 : CXW'(ec) - CXW'(1);
    cr = ((CXW'(ec) + CXW'(1)) < cols) ? CXW'(ec) + CXW'(1) : cols - CXW'(1);
    // row slots of the emitted row and its neighbours
    sl_e = (in_slot == 2'd0) ? 2'd2 : in_slot - 2'd1;
    if (input_row >= RXW'(2)) begin
      sl_d = (sl_e == 2'd0) ? 2'd2 : sl_e - 2'd1;
    end else begin
      sl_d = sl_e;
    end
    sl_u = (input_row < rows) ? in_slot : sl_e;
  end

  // grid counters and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vpr        <= VPR_RESET;
      nrows      <= ROWS_RESET;
      input_col  <= '0;
      input_row  <= '0;
      in_slot    <= 2'd0;
      emit_count <= '0;
    end else if (cfg.valid && (cfg.index == CFG_VERTICES_PER_ROW ||
                               cfg.index == CFG_VERTEX_ROWS)) begin
      if (cfg.index == CFG_VERTICES_PER_ROW) begin
        vpr <= cfg.data;
      end else begin
        nrows <= cfg.data;
      end
      input_col  <= '0;
      input_row  <= '0;
      in_slot    <= 2'd0;
      emit_count <= '0;
    end else if (accept) begin
      if (emit_go && last) begin
        input_col  <= '0;
        input_row  <= '0;
        in_slot    <= 2'd0;
        emit_count <= '0;
      end else begin
        if (emit_go) begin
          emit_count <= emit_count + ENW'(1);
        end
        if (is_vtx && vtx_ok) begin
          if (col_inc >= cols) begin
            input_col <= '0;
            input_row <= input_row + RXW'(1);
            in_slot   <= (in_slot == 2'd2) ? 2'd0 : in_slot + 2'd1;
          end else begin
            input_col <= col_inc[CW-1:0];
          end
        end
      end
    end
  end

  // position RAMs
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [POS_W-1:0] rx, ry, rz;

  assign waddr = mk_addr(in_slot, input_col);

  gvn_ram #(.WIDTH(POS_W), .DEPTH(DEPTH)) u_ram_x (
    .clk(clk), .we(wr_en), .waddr(waddr), .wdata(vtx_in.pos_x), .raddr(raddr), .rdata(rx)
  );
  gvn_ram #(.WIDTH(POS_W), .DEPTH(DEPTH)) u_ram_y (
    .clk(clk), .we(wr_en), .waddr(waddr), .wdata(vtx_in.pos_y), .raddr(raddr), .rdata(ry)
  );
  gvn_ram #(.WIDTH(POS_W), .DEPTH(DEPTH)) u_ram_z (
    .clk(clk), .we(wr_en), .waddr(waddr), .wdata(vtx_in.pos_z), .raddr(raddr), .rdata(rz)
  );

  // datapath registers
  logic [AW-1:0]    addr_l, addr_r, addr_d, addr_u;
  logic [POS_W-1:0] hx, hy, hz;
  logic [32:0]      dmag [6];
  logic             dsgn [6];
  logic [1:0]       s;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [62:0] cacc [3];
  logic [61:0]      cmag [3];
  logic             csgn [3];
  logic             big;
  logic [63:0]      sum;
  logic [63:0]      sq_rem, sq_res, sq_bit;
  logic [46:0]      num [3];
  logic [46:0]      dsh;
  logic [14:0]      q [3];
  logic             degen;
  logic [IDX_W-1:0] o_row, o_col;
  logic             o_last;

  // combinational helpers
  logic [32:0] dm_or;
  logic [61:0] cm_or;
  logic [61:0] cm_abs [3];
  logic [63:0] sum_sh;
  logic        degen_now;
  logic [63:0] sq_trial;
  logic [31:0] lval;
  logic [2:0]  ridx;

  function automatic logic signed [31:0] dop(input logic [32:0] m, input logic sg);
    logic signed [31:0] v;
    v = {2'b00, m[29:0]};
    return sg ? -v : v;
  endfunction

  function automatic logic [32:0] dabs(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
    logic signed [32:0] d;
    d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic logic dneg(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
    logic signed [32:0] d;
    d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
    return d[32];
  endfunction

  always_comb begin
    dm_or = '0;
    for (int k = 0; k < 6; k++) begin
      dm_or = dm_or | dmag[k];
    end
    cm_or = cmag[0] | cmag[1] | cmag[2];
    for (int j = 0; j < 3; j++) begin
      cm_abs[j] = cacc[j][62] ? 62'(-cacc[j]) : 62'(cacc[j]);
    end
    sum_sh    = sum << {s, 2'b00};
    degen_now = !big && !(sum_sh > DEGEN_LIMIT);
    sq_trial  = sq_res + sq_bit;
    lval      = (sq_res == '0) ? 32'd1 : sq_res[31:0];
    ridx      = 3'(cnt - 5'd1);
    case (cnt[1:0])
      2'd0:    raddr = addr_l;
      2'd1:    raddr = addr_r;
      2'd2:    raddr = addr_d;
      default: raddr = addr_u;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_SQ) begin
      case (cnt[1:0])
        2'd0: begin
          mul_a = {1'b0, cmag[0][30:0]};
        end
        2'd1: begin
          mul_a = {1'b0, cmag[1][30:0]};
        end
        2'd2: begin
          mul_a = {1'b0, cmag[2][30:0]};
        end
        default: begin
          mul_a = '0;
        end
      endcase
      mul_b = mul_a;
    end else begin
      case (cnt[2:0])
        3'd0: begin
          mul_a = dop(dmag[4], dsgn[4]);
          mul_b = dop(dmag[2], dsgn[2]);
        end
        3'd1: begin
          mul_a = dop(dmag[5], dsgn[5]);
          mul_b = dop(dmag[1], dsgn[1]);
        end
        3'd2: begin
          mul_a = dop(dmag[5], dsgn[5]);
          mul_b = dop(dmag[0], dsgn[0]);
        end
        3'd3: begin
          mul_a = dop(dmag[3], dsgn[3]);
          mul_b = dop(dmag[2], dsgn[2]);
        end
        3'd4: begin
          mul_a = dop(dmag[3], dsgn[3]);
          mul_b = dop(dmag[1], dsgn[1]);
        end
        3'd5: begin
          mul_a = dop(dmag[4], dsgn[4]);
          mul_b = dop(dmag[0], dsgn[0]);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  // sequencer state register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 5'd0 : cnt + 5'd1;
    end
  end

  // output register
  logic load_out;
  logic out_valid;

  // next state
  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && emit_go) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (cnt == 5'd4) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (dm_or[32:30] == '0) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt == 5'd6) begin
          state_next = ST_CMAG;
        end
      end
      ST_CMAG: begin
        state_next = ST_TSHIFT;
      end
      ST_TSHIFT: begin
        if (cm_or[61:31] == '0) begin
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        if (cnt == 5'd3) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = degen_now ? ST_DONE : ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt == 5'd31) begin
          state_next = ST_DIVINIT;
        end
      end
      ST_DIVINIT: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == 5'd14) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || nrm_out.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        addr_l <= mk_addr(sl_e, cl[CW-1:0]);
        addr_r <= mk_addr(sl_e, cr[CW-1:0]);
        addr_d <= mk_addr(sl_d, ec);
        addr_u <= mk_addr(sl_u, ec);
        o_row  <= IDX_W'(input_row - RXW'(1));
        o_col  <= IDX_W'(ec);
        o_last <= last;
        s      <= 2'd0;
      end
      ST_READ: begin
        // first read of a pair is held, second forms the difference
        if (cnt != 5'd0) begin
          if (ridx == 3'd0 || ridx == 3'd2) begin
            hx <= rx;
            hy <= ry;
            hz <= rz;
          end else if (ridx == 3'd1) begin
            dmag[0] <= dabs(rx, hx);
            dmag[1] <= dabs(ry, hy);
            dmag[2] <= dabs(rz, hz);
            dsgn[0] <= dneg(rx, hx);
            dsgn[1] <= dneg(ry, hy);
            dsgn[2] <= dneg(rz, hz);
          end else begin
            dmag[3] <= dabs(rx, hx);
            dmag[4] <= dabs(ry, hy);
            dmag[5] <= dabs(rz, hz);
            dsgn[3] <= dneg(rx, hx);
            dsgn[4] <= dneg(ry, hy);
            dsgn[5] <= dneg(rz, hz);
          end
        end
      end
      ST_SCALE: begin
        if (dm_or[32:30] != '0) begin
          for (int k = 0; k < 6; k++) begin
            dmag[k] <= dmag[k] >> 1;
          end
          s <= s + 2'd1;
        end
      end
      ST_MUL: begin
        // cross product terms, one product a cycle
        if (cnt != 5'd0) begin
          if (ridx[0] == 1'b0) begin
            cacc[ridx[2:1]] <= 63'(prod);
          end else begin
            cacc[ridx[2:1]] <= cacc[ridx[2:1]] - 63'(prod);
          end
        end
      end
      ST_CMAG: begin
        for (int j = 0; j < 3; j++) begin
          cmag[j] <= cm_abs[j];
          csgn[j] <= cacc[j][62];
        end
        big <= ((cm_abs[0] | cm_abs[1] | cm_abs[2]) >> 23) != '0;
      end
      ST_TSHIFT: begin
        if (cm_or[61:31] != '0) begin
          for (int j = 0; j < 3; j++) begin
            cmag[j] <= cmag[j] >> 1;
          end
        end
      end
      ST_SQ: begin
        if (cnt == 5'd1) begin
          sum <= 64'(prod);
        end else if (cnt != 5'd0) begin
          sum <= sum + 64'(prod);
        end
      end
      ST_DECIDE: begin
        degen  <= degen_now;
        sq_rem <= sum;
        sq_res <= '0;
        sq_bit <= 64'd1 << 62;
      end
      ST_SQRT: begin
        // bit-pair integer square root
        if (sq_rem >= sq_trial) begin
          sq_rem <= sq_rem - sq_trial;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      ST_DIVINIT: begin
        for (int j = 0; j < 3; j++) begin
          num[j] <= 47'({cmag[j][30:0], 14'b0}) + 47'(lval >> 1);
          q[j]   <= '0;
        end
        dsh <= 47'({lval, 14'b0});
      end
      ST_DIV: begin
        // restoring divide, three lanes sharing the divisor
        for (int j = 0; j < 3; j++) begin
          if (num[j] >= dsh) begin
            num[j] <= num[j] - dsh;
            q[j]   <= {q[j][13:0], 1'b1};
          end else begin
            q[j]   <= {q[j][13:0], 1'b0};
          end
        end
        dsh <= dsh >> 1;
      end
      default: begin
      end
    endcase
  end

  // final normal components
  logic signed [NRM_W-1:0] n_out [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic [14:0] qs;
      logic signed [NRM_W-1:0] qv;
      qs = (q[j] > ONE_Q14) ? ONE_Q14 : q[j];
      qv = NRM_W'(qs);
      if (degen) begin
        n_out[j] = (j == 1) ? NRM_W'(ONE_Q14) : '0;
      end else begin
        n_out[j] = csgn[j] ? -qv : qv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (nrm_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      nrm_out.normal_x    <= n_out[0];
      nrm_out.normal_y    <= n_out[1];
      nrm_out.normal_z    <= n_out[2];
      nrm_out.vertex_row  <= o_row;
      nrm_out.vertex_col  <= o_col;
      nrm_out.degenerate  <= degen;
      nrm_out.last_normal <= o_last;
    end
  end

  assign nrm_out.valid = out_valid;

endmodule
